### design/bamfq_pkg.sv
// Shared types, codes and constants of the record-to-FASTQ formatter.
// No dependencies; used by every module of the block but bamfq_ram.
`default_nettype none

package bamfq_pkg;

  // Item operation codes (input tuser)
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_NAME  = 2'd1;
  localparam logic [1:0] OP_BASE  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_SKIP_MASK    = 2'd0;
  localparam logic [1:0] REG_REVERSE_MASK = 2'd1;
  localparam logic [1:0] REG_QUAL_OFFSET  = 2'd2;

  localparam logic [15:0] SKIP_MASK_RST    = 16'd2048;
  localparam logic [15:0] REVERSE_MASK_RST = 16'd16;
  localparam logic [7:0]  QUAL_OFFSET_RST  = 8'd33;

  // Text characters
  localparam logic [7:0] CH_AT   = 8'd64;
  localparam logic [7:0] CH_NL   = 8'd10;
  localparam logic [7:0] CH_PLUS = 8'd43;
  localparam logic [7:0] CH_NUL  = 8'd0;
  localparam logic [7:0] CH_A    = 8'd65;
  localparam logic [7:0] CH_C    = 8'd67;
  localparam logic [7:0] CH_G    = 8'd71;
  localparam logic [7:0] CH_T    = 8'd84;
  localparam logic [7:0] CH_N    = 8'd78;

  // Nucleotide codes
  localparam logic [3:0] NT_A = 4'd1;
  localparam logic [3:0] NT_C = 4'd2;
  localparam logic [3:0] NT_G = 4'd4;
  localparam logic [3:0] NT_T = 4'd8;
  localparam logic [3:0] NT_N = 4'd15;

  // Record counters hold lengths up to 65536
  localparam int CNT_W = 17;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCNT_W = 3;

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 8;

  // One resolved queue entry; pair adds a trailing newline result
  typedef struct packed {
    logic [7:0] txt;
    logic       done;
    logic       err;
    logic       pair;
  } entry_t;

  // Base code to ASCII, complemented when rev is set; unknown codes give NUL
  function automatic logic [7:0] map_base(input logic [3:0] code, input logic rev);
    logic [7:0] ch;
    ch = CH_NUL;
    case (code)
      NT_A:    ch = rev ? CH_T : CH_A;
      NT_C:    ch = rev ? CH_G : CH_C;
      NT_G:    ch = rev ? CH_C : CH_G;
      NT_T:    ch = rev ? CH_A : CH_T;
      NT_N:    ch = CH_N;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### design/bam_record_to_fastq_formatter.sv
// Alignment record to FASTQ text formatter, top level.
// Input channel s_axis: tuser = operation (record start, name byte,
//   base and quality, emit tick), tlast = last name byte, tdata = record fields.
// Output channel m_axis: one FASTQ character per item; tlast marks the final
//   newline of a record, tuser flags a dropped over-length record and the last
//   result of an input item.
// Configuration: cfg_we_i writes register cfg_idx_i (skip mask, reverse mask,
//   quality offset) with cfg_data_i; the user writes only while idle (unchecked).
// Throughput: one input item per cycle while s_axis_tready is high; a final name
//   byte gives two results, backed by a four-entry queue.
// Path of an item: stage-one decode and buffer read, queue write, then the
//   output register that presents its first result.
// Bases and qualities go to a MAX_READ_LEN deep buffer RAM, one write per base
//   item and one registered read per emit tick.
// Reset: no record open, configuration at its defaults, queue and output empty.
// When the receiver stalls, the result holds in the output register and the
//   queue fills; s_axis_tready drops once the queue plus stage one is full.
`default_nettype none

module bam_record_to_fastq_formatter #(
  parameter int MAX_READ_LEN = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] record_flags, [31:16] read_length, [39:32] name_byte,
  // [43:40] base_code, [51:44] quality_score, [55:52] zero
  input  wire logic [bamfq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] text_byte
  output logic [bamfq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] length_error, [1] last_of_item
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  logic                         push, pop;
  bamfq_pkg::entry_t            push_entry, head;
  logic [bamfq_pkg::QCNT_W-1:0] q_count;
  logic                         out_err, out_last;

  bamfq_front #(
    .MAX_READ_LEN (MAX_READ_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tuser),
    .flags_i      (s_axis_tdata[15:0]),
    .len_i        (s_axis_tdata[31:16]),
    .name_byte_i  (s_axis_tdata[39:32]),
    .name_final_i (s_axis_tlast),
    .base_code_i  (s_axis_tdata[43:40]),
    .qual_i       (s_axis_tdata[51:44]),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  bamfq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .count_o      (q_count)
  );

  bamfq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .count_i     (q_count),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_txt_o   (m_axis_tdata),
    .out_done_o  (m_axis_tlast),
    .out_err_o   (out_err),
    .out_last_o  (out_last)
  );

  assign m_axis_tuser = {out_last, out_err};

endmodule

`default_nettype wire

### design/bamfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bamfq_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AW-1:0]           waddr_i,
  input  wire logic [WIDTH-1:0]        wdata_i,
  input  wire logic [AW-1:0]           raddr_i,
  output logic      [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/bamfq_front.sv
// Front part: accepts items, tracks record state, fills the read buffer
// and resolves one queue entry per item that gives text. Uses bamfq_pkg, bamfq_ram.
`default_nettype none

module bamfq_front #(
  parameter int MAX_READ_LEN = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [15:0]                   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [15:0]                   flags_i,
  input  wire logic [15:0]                   len_i,
  input  wire logic [7:0]                    name_byte_i,
  input  wire logic                          name_final_i,
  input  wire logic [3:0]                    base_code_i,
  input  wire logic [7:0]                    qual_i,
  input  wire logic [bamfq_pkg::QCNT_W-1:0]  q_count_i,
  output logic                               push_o,
  output bamfq_pkg::entry_t                  push_entry_o
);

  localparam int AW = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;
  localparam logic [bamfq_pkg::CNT_W-1:0] MAX_LEN = bamfq_pkg::CNT_W'(MAX_READ_LEN);

  typedef enum logic [2:0] {
    PH_IDLE, PH_NAME, PH_SEQ, PH_SEP, PH_QUAL, PH_FIN
  } phase_e;

  typedef enum logic [1:0] {
    SRC_LIT, SRC_BASE, SRC_QUAL
  } src_e;

  typedef struct packed {
    src_e       src;
    logic [7:0] txt;
    logic       done;
    logic       err;
    logic       pair;
  } cmd_t;

  logic [15:0] skip_mask_q, rev_mask_q;
  logic [7:0]  qual_off_q;

  phase_e                     phase_q, phase_d;
  logic                       skip_q, skip_d;
  logic                       rev_q, rev_d;
  logic [bamfq_pkg::CNT_W-1:0] rec_len_q, rec_len_d;
  logic [bamfq_pkg::CNT_W-1:0] wcount_q, wcount_d;
  logic [bamfq_pkg::CNT_W-1:0] eptr_q, eptr_d;

  logic  s1_valid_q, s1_valid_d;
  cmd_t  s1_cmd_q, cmd_d;

  logic        accept;
  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0] ram_wdata, ram_rdata;

  // Room in the queue for the item in stage one plus a new one
  assign in_ready_o = ({1'b0, q_count_i} + {{bamfq_pkg::QCNT_W{1'b0}}, s1_valid_q})
                      < (bamfq_pkg::QCNT_W+1)'(bamfq_pkg::QDEPTH);
  assign accept = in_valid_i && in_ready_o;

  // Item decode and record state update
  always_comb begin
    phase_e                      ph;
    logic [bamfq_pkg::CNT_W-1:0] ptr;
    logic [bamfq_pkg::CNT_W-1:0] pos;
    phase_d    = phase_q;
    skip_d     = skip_q;
    rev_d      = rev_q;
    rec_len_d  = rec_len_q;
    wcount_d   = wcount_q;
    eptr_d     = eptr_q;
    s1_valid_d = 1'b0;
    cmd_d      = '{src: SRC_LIT, txt: bamfq_pkg::CH_NUL, done: 1'b0, err: 1'b0, pair: 1'b0};
    ram_we     = 1'b0;
    ph         = phase_q;
    ptr        = eptr_q;
    pos        = rev_q ? (rec_len_q - 1'b1 - wcount_q) : wcount_q;
    ram_waddr  = pos[AW-1:0];
    ram_wdata  = {qual_i + qual_off_q, bamfq_pkg::map_base(base_code_i, rev_q)};
    ram_raddr  = eptr_q[AW-1:0];
    if (accept) begin
      case (op_i)
        bamfq_pkg::OP_START: begin
          phase_d  = PH_IDLE;
          wcount_d = '0;
          eptr_d   = '0;
          if ((flags_i & skip_mask_q) != 16'd0) begin
            skip_d = 1'b1;
          end else if ({1'b0, len_i} > MAX_LEN) begin
            skip_d     = 1'b1;
            s1_valid_d = 1'b1;
            cmd_d.err  = 1'b1;
          end else begin
            skip_d     = 1'b0;
            rec_len_d  = {1'b0, len_i};
            rev_d      = |(flags_i & rev_mask_q);
            phase_d    = PH_NAME;
            s1_valid_d = 1'b1;
            cmd_d.txt  = bamfq_pkg::CH_AT;
          end
        end
        bamfq_pkg::OP_NAME: begin
          if (!skip_q && phase_q == PH_NAME) begin
            s1_valid_d = 1'b1;
            cmd_d.txt  = name_byte_i;
            cmd_d.pair = name_final_i;
            if (name_final_i) begin
              phase_d = PH_SEQ;
            end
          end
        end
        bamfq_pkg::OP_BASE: begin
          if (!skip_q && phase_q == PH_SEQ && wcount_q < rec_len_q) begin
            ram_we   = 1'b1;
            wcount_d = wcount_q + 1'b1;
          end
        end
        bamfq_pkg::OP_TICK: begin
          if (!skip_q) begin
            // Sequence done: move on to the separator in the same tick
            if (ph == PH_SEQ && wcount_q >= rec_len_q && ptr >= rec_len_q) begin
              ph  = PH_SEP;
              ptr = '0;
            end
            if (ph == PH_QUAL && ptr >= rec_len_q) begin
              ph = PH_FIN;
            end
            ram_raddr = ptr[AW-1:0];
            case (ph)
              PH_SEQ: begin
                if (wcount_q >= rec_len_q) begin
                  s1_valid_d = 1'b1;
                  cmd_d.src  = SRC_BASE;
                  eptr_d     = ptr + 1'b1;
                end
              end
              PH_SEP: begin
                s1_valid_d = 1'b1;
                cmd_d.txt  = (ptr == bamfq_pkg::CNT_W'(1)) ? bamfq_pkg::CH_PLUS
                                                           : bamfq_pkg::CH_NL;
                if (ptr >= bamfq_pkg::CNT_W'(2)) begin
                  phase_d = PH_QUAL;
                  eptr_d  = '0;
                end else begin
                  phase_d = PH_SEP;
                  eptr_d  = ptr + 1'b1;
                end
              end
              PH_QUAL: begin
                s1_valid_d = 1'b1;
                cmd_d.src  = SRC_QUAL;
                phase_d    = PH_QUAL;
                eptr_d     = ptr + 1'b1;
              end
              PH_FIN: begin
                s1_valid_d = 1'b1;
                cmd_d.txt  = bamfq_pkg::CH_NL;
                cmd_d.done = 1'b1;
                phase_d    = PH_IDLE;
                eptr_d     = '0;
                skip_d     = 1'b1;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Read buffer: quality in the upper byte, base character in the lower
  bamfq_ram #(
    .WIDTH (16),
    .DEPTH (MAX_READ_LEN)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_mask_q <= bamfq_pkg::SKIP_MASK_RST;
      rev_mask_q  <= bamfq_pkg::REVERSE_MASK_RST;
      qual_off_q  <= bamfq_pkg::QUAL_OFFSET_RST;
      phase_q     <= PH_IDLE;
      skip_q      <= 1'b1;
      rev_q       <= 1'b0;
      rec_len_q   <= '0;
      wcount_q    <= '0;
      eptr_q      <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bamfq_pkg::REG_SKIP_MASK:    skip_mask_q <= cfg_data_i;
          bamfq_pkg::REG_REVERSE_MASK: rev_mask_q  <= cfg_data_i;
          bamfq_pkg::REG_QUAL_OFFSET:  qual_off_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      phase_q    <= phase_d;
      skip_q     <= skip_d;
      rev_q      <= rev_d;
      rec_len_q  <= rec_len_d;
      wcount_q   <= wcount_d;
      eptr_q     <= eptr_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Stage-one command payload
  always_ff @(posedge clk_i) begin
    s1_cmd_q <= cmd_d;
  end

  // Resolve buffer reads into a queue entry
  always_comb begin
    push_o            = s1_valid_q;
    push_entry_o.done = s1_cmd_q.done;
    push_entry_o.err  = s1_cmd_q.err;
    push_entry_o.pair = s1_cmd_q.pair;
    case (s1_cmd_q.src)
      SRC_BASE: push_entry_o.txt = ram_rdata[7:0];
      SRC_QUAL: push_entry_o.txt = ram_rdata[15:8];
      default:  push_entry_o.txt = s1_cmd_q.txt;
    endcase
  end

  a_idle_when_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) == skip_q)
    else $error("record open flag and phase disagree");

  a_wcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skip_q |-> (wcount_q <= rec_len_q))
    else $error("more bases stored than the record length");

  a_sep_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SEP) |-> (eptr_q < bamfq_pkg::CNT_W'(3)))
    else $error("separator pointer out of range");

endmodule

`default_nettype wire

### design/bamfq_queue.sv
// Short FIFO of resolved entries between the front and the back part.
// Uses bamfq_pkg.
`default_nettype none

module bamfq_queue (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire bamfq_pkg::entry_t            push_entry_i,
  input  wire logic                         pop_i,
  output bamfq_pkg::entry_t                 head_o,
  output logic [bamfq_pkg::QCNT_W-1:0]      count_o
);

  bamfq_pkg::entry_t entry_q [bamfq_pkg::QDEPTH];
  logic [bamfq_pkg::QAW-1:0]    wptr_q, rptr_q;
  logic [bamfq_pkg::QCNT_W-1:0] count_q;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign head_o  = entry_q[rptr_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < bamfq_pkg::QCNT_W'(bamfq_pkg::QDEPTH) || pop_i))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue underflow");

endmodule

`default_nettype wire

### design/bamfq_back.sv
// Back part: expands queue entries into result items and holds the
// output register. Uses bamfq_pkg.
`default_nettype none

module bamfq_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bamfq_pkg::entry_t            head_i,
  input  wire logic [bamfq_pkg::QCNT_W-1:0] count_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [7:0]                        out_txt_o,
  output logic                              out_done_o,
  output logic                              out_err_o,
  output logic                              out_last_o
);

  logic       out_valid_q, pend_nl_q;
  logic [7:0] txt_q;
  logic       done_q, err_q, last_q;
  logic       take;

  assign take  = !out_valid_q || out_ready_i;
  assign pop_o = take && !pend_nl_q && (count_i != '0);

  // Output register; a pending newline goes out before the next entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_nl_q   <= 1'b0;
      txt_q       <= bamfq_pkg::CH_NUL;
      done_q      <= 1'b0;
      err_q       <= 1'b0;
      last_q      <= 1'b0;
    end else if (take) begin
      if (pend_nl_q) begin
        out_valid_q <= 1'b1;
        pend_nl_q   <= 1'b0;
        txt_q       <= bamfq_pkg::CH_NL;
        done_q      <= 1'b0;
        err_q       <= 1'b0;
        last_q      <= 1'b1;
      end else if (pop_o) begin
        out_valid_q <= 1'b1;
        pend_nl_q   <= head_i.pair;
        txt_q       <= head_i.txt;
        done_q      <= head_i.done;
        err_q       <= head_i.err;
        last_q      <= !head_i.pair;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_txt_o   = txt_q;
  assign out_done_o  = done_q;
  assign out_err_o   = err_q;
  assign out_last_o  = last_q;

  a_pend_has_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_nl_q |-> (out_valid_q && !last_q))
    else $error("newline pending without its first result");

endmodule

`default_nettype wire
